@@ rtl/assert_macros.svh @@
// Assertion macros of the tail-drop queue, included by alt_ctrl.
// Define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ALT_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("check failed");
`define ALT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define ALT_ASSERT(lbl, clk, rst, prop)
`define ALT_NEVER(lbl, clk, rst, expr)
`endif
`endif

@@ rtl/alt_pkg.sv @@
// Types, codes and constants of the adaptive-limit tail-drop queue.
// No dependencies; imported by alt_ifs, alt_ctrl, the top level and the testbench.
package alt_pkg;

   localparam int DEPTH    = 1024;
   localparam int DESC_W   = 32;
   localparam int PTR_W    = $clog2(DEPTH);
   localparam int CNT_W    = 11;
   localparam int LIM_W    = 11;
   localparam int TICK_W   = 16;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 4;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [LIM_W-1:0] LIMIT_MAX   = LIM_W'(DEPTH);
   localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(1000);
   localparam logic [LIM_W-1:0] LIMIT_STEP  = LIM_W'(10);
   localparam logic [LIM_W-1:0] LIMIT_FLOOR = LIM_W'(20);
   localparam logic [TICK_W-1:0] INTERVAL_RESET = TICK_W'(1000);

   localparam logic [OP_W-1:0] OP_ENQ  = 2'd0;
   localparam logic [OP_W-1:0] OP_DEQ  = 2'd1;
   localparam logic [OP_W-1:0] OP_PEEK = 2'd2;
   localparam logic [OP_W-1:0] OP_TICK = 2'd3;

   localparam logic [STATUS_W-1:0] ST_STORED    = 4'd0;
   localparam logic [STATUS_W-1:0] ST_DROPPED   = 4'd1;
   localparam logic [STATUS_W-1:0] ST_DEQUEUED  = 4'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 4'd3;
   localparam logic [STATUS_W-1:0] ST_PEEKED    = 4'd4;
   localparam logic [STATUS_W-1:0] ST_TICK      = 4'd5;
   localparam logic [STATUS_W-1:0] ST_LIMIT_UP  = 4'd6;
   localparam logic [STATUS_W-1:0] ST_LIMIT_DN  = 4'd7;
   localparam logic [STATUS_W-1:0] ST_UNCHANGED = 4'd8;

   localparam logic [CSR_IDX_W-1:0] REG_INITIAL_LIMIT  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INTERVAL_TICKS = 1'd1;

   typedef struct packed {
      logic             wr_en;
      logic [PTR_W-1:0] wr_addr;
      logic             rd_en;
      logic [PTR_W-1:0] rd_addr;
   } mem_cmd_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [CNT_W-1:0]    occupancy;
      logic [LIM_W-1:0]    limit;
      logic                has_head;
   } res_type;

   function automatic logic [LIM_W-1:0] clamp_limit(input logic [LIM_W-1:0] v);
      logic [LIM_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = LIM_W'(1);
      end else if (v > LIMIT_MAX) begin
         r = LIMIT_MAX;
      end
      return r;
   endfunction

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      r = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
      return r;
   endfunction

endpackage

@@ rtl/alt_ifs.sv @@
// Handshake channels of the tail-drop queue: request, response, register write.
// Depends on alt_pkg.
interface alt_req_if;
   import alt_pkg::*;
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   op;
   logic [DESC_W-1:0] descriptor;
   modport source (output valid, output op, output descriptor, input ready);
   modport sink   (input valid, input op, input descriptor, output ready);
endinterface

interface alt_rsp_if;
   import alt_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [DESC_W-1:0]   head_descriptor;
   logic [CNT_W-1:0]    occupancy;
   logic [LIM_W-1:0]    current_limit;
   modport source (output valid, output status, output head_descriptor,
                   output occupancy, output current_limit, input ready);
   modport sink   (input valid, input status, input head_descriptor,
                   input occupancy, input current_limit, output ready);
endinterface

interface alt_csr_if;
   import alt_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/alt_desc_ram.sv @@
// Simple dual-port descriptor memory with registered read data.
// No dependencies.
module alt_desc_ram #(
   parameter int DEPTH_P = 1024,
   parameter int WIDTH_P = 32
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH_P)-1:0] wr_addr,
   input  logic [WIDTH_P-1:0]         wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH_P)-1:0] rd_addr,
   output logic [WIDTH_P-1:0]         rd_data
);
   logic [WIDTH_P-1:0] mem [DEPTH_P];
   logic [WIDTH_P-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // hold read data while the response stalls
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

@@ rtl/alt_ctrl.sv @@
// Queue control: pointers, occupancy, adaptive limit, tick counter, result register.
// Depends on alt_pkg and assert_macros.svh.
`include "assert_macros.svh"
module alt_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  logic [alt_pkg::OP_W-1:0]      op,
   input  logic                          csr_wr,
   input  logic [alt_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [alt_pkg::CSR_DATA_W-1:0] csr_data,
   output alt_pkg::mem_cmd_type          mem_cmd,
   output alt_pkg::res_type              result
);
   import alt_pkg::*;

   logic [PTR_W-1:0]  head_ff, head_in;
   logic [PTR_W-1:0]  tail_ff, tail_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [LIM_W-1:0]  limit_ff, limit_in;
   logic [TICK_W-1:0] tick_ff, tick_in;
   logic [TICK_W-1:0] interval_ff, interval_in;
   res_type           result_ff, result_in;

   logic [STATUS_W-1:0] status;
   logic                has_head;
   logic                full;
   logic [LIM_W-1:0]    thr;
   logic [LIM_W:0]      grown;
   logic [LIM_W-1:0]    grown_sat;
   logic [TICK_W-1:0]   tick_inc;
   logic [TICK_W-1:0]   period;

   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      cnt_in      = cnt_ff;
      limit_in    = limit_ff;
      tick_in     = tick_ff;
      interval_in = interval_ff;
      status      = ST_TICK;
      has_head    = 1'b0;
      mem_cmd     = '{wr_en: 1'b0, wr_addr: tail_ff, rd_en: load, rd_addr: head_ff};

      full      = (cnt_ff >= CNT_W'(limit_ff)) || (cnt_ff >= CNT_W'(DEPTH));
      thr       = limit_ff >> 1;
      grown     = {1'b0, limit_ff} + {1'b0, LIMIT_STEP};
      grown_sat = (grown > {1'b0, LIMIT_MAX}) ? LIMIT_MAX : grown[LIM_W-1:0];
      tick_inc  = tick_ff + 1'b1;
      period    = (interval_ff == '0) ? TICK_W'(1) : interval_ff;

      if (load) begin
         unique case (op)
            OP_ENQ: begin
               if (full) begin
                  status = ST_DROPPED;
               end else begin
                  status        = ST_STORED;
                  mem_cmd.wr_en = 1'b1;
                  tail_in       = next_ptr(tail_ff);
                  cnt_in        = cnt_ff + 1'b1;
               end
            end
            OP_DEQ: begin
               if (cnt_ff == '0) begin
                  status = ST_EMPTY;
               end else begin
                  status   = ST_DEQUEUED;
                  has_head = 1'b1;
                  head_in  = next_ptr(head_ff);
                  cnt_in   = cnt_ff - 1'b1;
               end
            end
            OP_PEEK: begin
               if (cnt_ff == '0) begin
                  status = ST_EMPTY;
               end else begin
                  status   = ST_PEEKED;
                  has_head = 1'b1;
               end
            end
            OP_TICK: begin
               if (tick_inc >= period) begin
                  tick_in = '0;
                  // grow above half the limit, shrink below a quarter while above the floor
                  if (cnt_ff > CNT_W'(thr)) begin
                     if (grown_sat == limit_ff) begin
                        status = ST_UNCHANGED;
                     end else begin
                        status   = ST_LIMIT_UP;
                        limit_in = grown_sat;
                     end
                  end else if (cnt_ff < CNT_W'(thr >> 1) && limit_ff > LIMIT_FLOOR) begin
                     status   = ST_LIMIT_DN;
                     limit_in = limit_ff - LIMIT_STEP;
                  end else begin
                     status = ST_UNCHANGED;
                  end
               end else begin
                  tick_in = tick_inc;
                  status  = ST_TICK;
               end
            end
            default: begin
               status = ST_TICK;
            end
         endcase
      end

      if (csr_wr) begin
         unique case (csr_index)
            REG_INITIAL_LIMIT:  limit_in    = clamp_limit(csr_data[LIM_W-1:0]);
            REG_INTERVAL_TICKS: interval_in = csr_data[TICK_W-1:0];
            default:            interval_in = interval_ff;
         endcase
      end

      result_in = '{status: status, occupancy: cnt_in, limit: limit_in, has_head: has_head};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         tail_ff     <= '0;
         cnt_ff      <= '0;
         limit_ff    <= LIMIT_RESET;
         tick_ff     <= '0;
         interval_ff <= INTERVAL_RESET;
      end else begin
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         cnt_ff      <= cnt_in;
         limit_ff    <= limit_in;
         tick_ff     <= tick_in;
         interval_ff <= interval_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

   `ALT_NEVER(a_occ_bound, clock, reset, cnt_ff > CNT_W'(DEPTH))
   `ALT_NEVER(a_limit_range, clock, reset, limit_ff == '0 || limit_ff > LIMIT_MAX)
   `ALT_ASSERT(a_ptr_empty, clock, reset, (cnt_ff == '0) |-> (head_ff == tail_ff))
   `ALT_ASSERT(a_enq_count, clock, reset,
      (load && op == OP_ENQ && cnt_ff < CNT_W'(limit_ff)) |=> (cnt_ff == $past(cnt_ff) + 1'b1))
endmodule

@@ rtl/adaptive_limit_tail_drop_fifo_core.sv @@
// Top level of the adaptive-limit tail-drop descriptor queue.
// Depends on alt_pkg, alt_ifs, alt_desc_ram and alt_ctrl.
//
// Usage:
//   req_chan  carries one operation per item: enqueue, dequeue, peek or tick,
//             with the descriptor used by enqueue.
//   rsp_chan  returns exactly one result item per request item, in order:
//             status, head descriptor, occupancy and limit after the item.
//   csr_chan  writes the initial limit (index 0, also loads the limit in
//             force) and the adaptation interval (index 1); always ready.
//             Write it only while no request is in flight.
// The response is valid in the cycle after the request is accepted. Throughput
// is one item per cycle while rsp_chan does not stall: the state update is
// combinational, each accepted item reads the head slot of the descriptor
// memory, and a stored enqueue also writes the tail slot.
// Reset clears pointers, occupancy and tick count, sets the limit and the
// interval to 1000. Memory contents stay undefined until written.
// When rsp_chan stalls, the response and its read data hold, and req_chan
// drops ready until the held response is taken.
module adaptive_limit_tail_drop_fifo_core (
   input logic   clock,
   input logic   reset,
   alt_req_if.sink   req_chan,
   alt_rsp_if.source rsp_chan,
   alt_csr_if.sink   csr_chan
);
   import alt_pkg::*;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              accept;
   mem_cmd_type       mem_cmd;
   res_type           result;
   logic [DESC_W-1:0] rd_data;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   alt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .op        (req_chan.op),
      .csr_wr    (csr_chan.valid),
      .csr_index (csr_chan.index),
      .csr_data  (csr_chan.data),
      .mem_cmd   (mem_cmd),
      .result    (result)
   );

   alt_desc_ram #(
      .DEPTH_P (DEPTH),
      .WIDTH_P (DESC_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_cmd.wr_en),
      .wr_addr (mem_cmd.wr_addr),
      .wr_data (req_chan.descriptor),
      .rd_en   (mem_cmd.rd_en),
      .rd_addr (mem_cmd.rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.status          = result.status;
   assign rsp_chan.head_descriptor = result.has_head ? rd_data : '0;
   assign rsp_chan.occupancy       = result.occupancy;
   assign rsp_chan.current_limit   = result.limit;
endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of adaptive_limit_tail_drop_fifo_core: drives enqueue, dequeue,
// peek and tick items and checks every result against a cycle-free model of the queue.
// Depends on alt_pkg, alt_ifs and the RTL of the core.
module tb_top;
   import alt_pkg::*;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [DESC_W-1:0]   head;
      logic [CNT_W-1:0]    occupancy;
      logic [LIM_W-1:0]    limit;
   } queue_answer_type;

   // Shadow copy of the descriptor queue and its adaptive limit, plus the
   // answers still owed by the block, oldest first.
   class queue_answer_book;
      logic [DESC_W-1:0] slots [DEPTH];
      logic [PTR_W-1:0]  head_at;
      logic [PTR_W-1:0]  tail_at;
      logic [CNT_W-1:0]  held;
      logic [LIM_W-1:0]  limit;
      logic [TICK_W-1:0] ticks;
      logic [TICK_W-1:0] interval;
      queue_answer_type  awaited [$];
      int unsigned       checked;
      int unsigned       failures;

      function new();
         head_at  = '0;
         tail_at  = '0;
         held     = '0;
         ticks    = '0;
         limit    = LIMIT_RESET;
         interval = INTERVAL_RESET;
         checked  = 0;
         failures = 0;
      endfunction

      function logic [PTR_W-1:0] step_ptr(logic [PTR_W-1:0] p);
         return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
      endfunction

      function void load_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         logic [LIM_W-1:0] v;
         v = data[LIM_W-1:0];
         if (idx == REG_INITIAL_LIMIT) begin
            // out-of-range limits saturate to 1 .. DEPTH
            if (v == '0) begin
               limit = LIM_W'(1);
            end else if (v > LIMIT_MAX) begin
               limit = LIMIT_MAX;
            end else begin
               limit = v;
            end
         end else if (idx == REG_INTERVAL_TICKS) begin
            interval = TICK_W'(data);
         end
      endfunction

      function logic [STATUS_W-1:0] adapt_limit();
         logic [LIM_W-1:0] half;
         logic [LIM_W:0]   grown;
         half = limit >> 1;
         if (held > half) begin
            grown = limit + LIMIT_STEP;
            if (grown > LIMIT_MAX) begin
               grown = LIMIT_MAX;
            end
            if (grown == limit) begin
               return ST_UNCHANGED;
            end
            limit = grown[LIM_W-1:0];
            return ST_LIMIT_UP;
         end
         if (held < (half >> 1) && limit > LIMIT_FLOOR) begin
            limit = limit - LIMIT_STEP;
            return ST_LIMIT_DN;
         end
         return ST_UNCHANGED;
      endfunction

      function void note_request(logic [OP_W-1:0] op, logic [DESC_W-1:0] desc);
         queue_answer_type  a;
         logic [TICK_W-1:0] period;
         a = '0;
         case (op) inside
            OP_ENQ: begin
               if (held >= limit || held >= CNT_W'(DEPTH)) begin
                  a.status = ST_DROPPED;
               end else begin
                  slots[tail_at] = desc;
                  tail_at = step_ptr(tail_at);
                  held = held + 1'b1;
                  a.status = ST_STORED;
               end
            end
            OP_DEQ, OP_PEEK: begin
               if (held == '0) begin
                  a.status = ST_EMPTY;
               end else begin
                  a.head = slots[head_at];
                  if (op == OP_DEQ) begin
                     head_at = step_ptr(head_at);
                     held = held - 1'b1;
                     a.status = ST_DEQUEUED;
                  end else begin
                     a.status = ST_PEEKED;
                  end
               end
            end
            default: begin
               period = (interval == '0) ? TICK_W'(1) : interval;
               ticks = ticks + 1'b1;
               if (ticks >= period) begin
                  ticks = '0;
                  a.status = adapt_limit();
               end else begin
                  a.status = ST_TICK;
               end
            end
         endcase
         a.occupancy = held;
         a.limit = limit;
         awaited.push_back(a);
      endfunction

      task report(input string msg);
         $display("MISMATCH @%0t: %s", $realtime, msg);
         failures++;
      endtask

      task check_result(input queue_answer_type got);
         queue_answer_type want;
         if (awaited.size() == 0) begin
            report($sformatf("result with nothing owed, status %0d", got.status));
            return;
         end
         want = awaited.pop_front();
         checked++;
         if (got.status != want.status) begin
            report($sformatf("result %0d status %0d, want %0d",
                             checked, got.status, want.status));
         end
         if (got.head != want.head) begin
            report($sformatf("result %0d head %h, want %h", checked, got.head, want.head));
         end
         if (got.occupancy != want.occupancy) begin
            report($sformatf("result %0d occupancy %0d, want %0d",
                             checked, got.occupancy, want.occupancy));
         end
         if (got.limit != want.limit) begin
            report($sformatf("result %0d limit %0d, want %0d",
                             checked, got.limit, want.limit));
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;

   alt_req_if req_chan ();
   alt_rsp_if rsp_chan ();
   alt_csr_if csr_chan ();

   queue_answer_book book = new();
   int unsigned      sender_calm;

   adaptive_limit_tail_drop_fifo_core uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int unsigned gap_length();
      return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
   endfunction

   task automatic send_item(input logic [OP_W-1:0] op, input logic [DESC_W-1:0] desc);
      @(negedge clock);
      req_chan.valid      <= 1'b1;
      req_chan.op         <= op;
      req_chan.descriptor <= desc;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      book.note_request(op, desc);
   endtask

   task automatic sender_pause(input int unsigned cycles);
      if (cycles == 0) begin
         return;
      end
      @(negedge clock);
      req_chan.valid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic pace_sender();
      int unsigned r;
      if (sender_calm > 0) begin
         sender_calm--;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 4) begin
            sender_calm = $urandom_range(30, 150);
         end else if (r < 30) begin
            sender_pause(gap_length());
         end
      end
   endtask

   // Hold the request side until every owed result has been taken.
   task automatic wait_drained();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (book.awaited.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= data;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      book.load_register(idx, data);
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   task automatic run_phase(input logic [CSR_DATA_W-1:0] limit_data,
                            input logic [CSR_DATA_W-1:0] interval_data,
                            input int unsigned count, input int unsigned enq_pct,
                            input int unsigned deq_pct, input int unsigned peek_pct);
      int unsigned      r;
      logic [OP_W-1:0]  op;
      wait_drained();
      write_register(REG_INITIAL_LIMIT, limit_data);
      write_register(REG_INTERVAL_TICKS, interval_data);
      for (int unsigned n = 0; n < count; n++) begin
         if (n == count / 2) begin
            wait_drained();
         end
         pace_sender();
         r = $urandom_range(0, 99);
         if (r < enq_pct) begin
            op = OP_ENQ;
         end else if (r < enq_pct + deq_pct) begin
            op = OP_DEQ;
         end else if (r < enq_pct + deq_pct + peek_pct) begin
            op = OP_PEEK;
         end else begin
            op = OP_TICK;
         end
         send_item(op, $urandom());
      end
   endtask

   always @(posedge clock) begin : watch_results
      queue_answer_type seen;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         seen.status    = rsp_chan.status;
         seen.head      = rsp_chan.head_descriptor;
         seen.occupancy = rsp_chan.occupancy;
         seen.limit     = rsp_chan.current_limit;
         book.check_result(seen);
      end
   end

   initial begin : take_results
      int unsigned stall_left;
      int unsigned calm_left;
      int unsigned holds_done;
      int unsigned r;
      stall_left = 0;
      calm_left  = 0;
      holds_done = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_done < 2 && book.checked >= 300 + holds_done * 1000) begin
            // long hold-off: back-pressure must reach the request side
            holds_done++;
            rsp_chan.ready <= 1'b0;
            repeat (120) @(negedge clock);
            rsp_chan.ready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_chan.ready <= 1'b1;
            if (calm_left > 0) begin
               calm_left--;
            end else begin
               r = $urandom_range(0, 99);
               if (r < 5) begin
                  calm_left = $urandom_range(40, 200);
               end else if (r < 30) begin
                  stall_left = gap_length();
               end
            end
         end
      end
   end

   initial begin : drive_requests
      reset = 1'b1;
      sender_calm = 0;
      req_chan.valid      = 1'b0;
      req_chan.op         = OP_ENQ;
      req_chan.descriptor = '0;
      csr_chan.valid      = 1'b0;
      csr_chan.index      = REG_INITIAL_LIMIT;
      csr_chan.data       = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty queue, reset settings, descriptor extremes
      send_item(OP_DEQ, '1);
      send_item(OP_PEEK, '0);
      send_item(OP_TICK, 32'h5555_AAAA);
      send_item(OP_ENQ, '1);
      send_item(OP_ENQ, '0);
      send_item(OP_PEEK, 32'hAAAA_5555);
      send_item(OP_DEQ, '0);
      send_item(OP_DEQ, '0);
      send_item(OP_DEQ, '0);

      // zero limit acts as one, zero interval adapts on every tick
      wait_drained();
      write_register(REG_INITIAL_LIMIT, 16'h0000);
      write_register(REG_INTERVAL_TICKS, 16'h0000);
      send_item(OP_ENQ, 32'hA5A5_5A5A);
      send_item(OP_ENQ, 32'h0000_0001);
      send_item(OP_TICK, '0);
      send_item(OP_TICK, '0);

      // oversized limit saturates at the depth, then shrinks on a quiet queue
      wait_drained();
      write_register(REG_INITIAL_LIMIT, 16'hFFFF);
      write_register(REG_INTERVAL_TICKS, 16'd3);
      repeat (3) send_item(OP_TICK, '0);

      // lower the interval below the running tick count
      wait_drained();
      write_register(REG_INTERVAL_TICKS, 16'hFFFF);
      repeat (3) send_item(OP_TICK, '0);
      wait_drained();
      write_register(REG_INTERVAL_TICKS, 16'd2);
      send_item(OP_TICK, '0);
      send_item(OP_DEQ, '0);

      run_phase(16'd30, 16'd1, 90, 45, 30, 10);
      run_phase(16'd25, 16'd4, 90, 60, 20, 5);
      // limit drops below what the queue already holds
      run_phase(16'd5, 16'd2, 60, 45, 35, 10);
      run_phase({5'($urandom()), 11'($urandom_range(1, 60))}, 16'($urandom_range(0, 8)),
                80, 40, 35, 10);
      run_phase({5'($urandom()), 11'($urandom_range(0, 2047))}, 16'($urandom()),
                60, 35, 35, 15);
      // fill to the full depth and let the limit grow into the ceiling
      run_phase(16'd1024, 16'd1, 1150, 94, 2, 2);
      run_phase(16'd1000, 16'd7, 80, 10, 75, 10);

      wait_drained();
      repeat (10) @(posedge clock);
      if (book.failures == 0 && book.awaited.size() == 0) begin
         $display("adaptive_limit_tail_drop_fifo_core regression: pass");
      end else begin
         $display("adaptive_limit_tail_drop_fifo_core regression: fail");
      end
      $finish;
   end

   initial begin : watchdog
      #20_000_000;
      $display("adaptive_limit_tail_drop_fifo_core regression: fail");
      $finish;
   end

endmodule
